/* design/stt_pkg.sv */
package stt_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = IDX_W + 1;
  localparam int TICK_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_W     = 4;

  // Entry status codes
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_BIND  = 3'd1,
    OP_FREE  = 3'd2,
    OP_START = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_ACK       = 2'd1,
    KIND_EXPIRY    = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ALLOC,
    BK_TICK
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [TICK_W-1:0]  timeout;
    logic [BYTE_W-1:0]  ev_byte;
    logic [QUEUE_W-1:0] queue;
  } item_t;

endpackage

/* design/software_timer_table_top.sv */
// Bind, free and start give their result through the command queue and output register;
// allocate scans up from entry 0 and returns the lowest free entry, or a failure if none.
// A tick walks the table one entry per cycle, paused while an expiry waits for output,
// then gives tick done; the walk holds the back part. Throughput: bind, free and start
// one per cycle via the 2-deep command queue unless a stall, allocate or tick holds them.
// Reset (rst, synchronous): all entries free, tick count zero, queue and output empty.
module software_timer_table_top #(
  parameter int NUM_TIMERS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [2:0]                    command,
  input  logic [stt_pkg::IDX_W-1:0]     timer_index,
  input  logic [stt_pkg::TICK_W-1:0]    timeout_ticks,
  input  logic [stt_pkg::BYTE_W-1:0]    event_byte,
  input  logic [stt_pkg::QUEUE_W-1:0]   queue_id,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    kind,
  output logic [stt_pkg::IDX_W-1:0]     entry_index,
  output logic                          success,
  output logic [stt_pkg::BYTE_W-1:0]    fired_byte,
  output logic [stt_pkg::QUEUE_W-1:0]   fired_queue,
  output logic [stt_pkg::TICK_W-1:0]    tick_total,
  output logic                          last
);

  logic           push_valid;
  logic           push_ready;
  stt_pkg::item_t push_item;
  logic           q_valid;
  logic           q_pop;
  stt_pkg::item_t q_item;

  stt_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .timer_index   (timer_index),
    .timeout_ticks (timeout_ticks),
    .event_byte    (event_byte),
    .queue_id      (queue_id),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  stt_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .kind        (kind),
    .entry_index (entry_index),
    .success     (success),
    .fired_byte  (fired_byte),
    .fired_queue (fired_queue),
    .tick_total  (tick_total),
    .last        (last)
  );

  a_nonlast_is_expiry : assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> kind == stt_pkg::KIND_EXPIRY)
    else $error("non-final result is not an expiry");

  a_fail_only_alloc : assert property (@(posedge clk) disable iff (rst)
    res_valid && !success |-> kind == stt_pkg::KIND_ALLOC && entry_index == '0)
    else $error("failure flag on a result that is not an allocate reply");

  a_pop_needs_item : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command taken from an empty queue");

  a_tick_step : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready ##1 res_valid && kind == stt_pkg::KIND_TICK_DONE
      && $past(kind) == stt_pkg::KIND_TICK_DONE
    |-> tick_total == $past(tick_total) + 32'd1)
    else $error("tick count moved by other than one between tick commands");

endmodule

/* design/stt_front.sv */
module stt_front #(
  parameter int NUM_TIMERS = 32
) (
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [2:0]                    command,
  input  logic [stt_pkg::IDX_W-1:0]     timer_index,
  input  logic [stt_pkg::TICK_W-1:0]    timeout_ticks,
  input  logic [stt_pkg::BYTE_W-1:0]    event_byte,
  input  logic [stt_pkg::QUEUE_W-1:0]   queue_id,
  output logic                          push_valid,
  input  logic                          push_ready,
  output stt_pkg::item_t                push_item
);

  localparam int ENTRIES = (NUM_TIMERS > stt_pkg::MAX_ENTRIES) ? stt_pkg::MAX_ENTRIES :
                           ((NUM_TIMERS < 1) ? 1 : NUM_TIMERS);

  logic known;

  always_comb begin
    case (command)
      stt_pkg::OP_ALLOC,
      stt_pkg::OP_BIND,
      stt_pkg::OP_FREE,
      stt_pkg::OP_START,
      stt_pkg::OP_TICK: known = 1'b1;
      default:          known = 1'b0;
    endcase
  end

  // Accept whenever the queue has room; drop unknown commands here
  assign cmd_ready  = push_ready;
  assign push_valid = cmd_valid && known;

  always_comb begin
    push_item.op       = stt_pkg::op_t'(command);
    push_item.idx      = timer_index;
    push_item.in_range = {1'b0, timer_index} < stt_pkg::CNT_W'(ENTRIES);
    push_item.timeout  = timeout_ticks;
    push_item.ev_byte  = event_byte;
    push_item.queue    = queue_id;
  end

endmodule

/* design/stt_queue.sv */
module stt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  stt_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output stt_pkg::item_t pop_item
);

  stt_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/stt_back.sv */
module stt_back #(
  parameter int NUM_TIMERS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  stt_pkg::item_t                q_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    kind,
  output logic [stt_pkg::IDX_W-1:0]     entry_index,
  output logic                          success,
  output logic [stt_pkg::BYTE_W-1:0]    fired_byte,
  output logic [stt_pkg::QUEUE_W-1:0]   fired_queue,
  output logic [stt_pkg::TICK_W-1:0]    tick_total,
  output logic                          last
);

  localparam int ENTRIES = (NUM_TIMERS > stt_pkg::MAX_ENTRIES) ? stt_pkg::MAX_ENTRIES :
                           ((NUM_TIMERS < 1) ? 1 : NUM_TIMERS);
  localparam logic [stt_pkg::CNT_W-1:0] SCAN_END = stt_pkg::CNT_W'(ENTRIES);
  localparam int BQ_W = stt_pkg::BYTE_W + stt_pkg::QUEUE_W;

  stt_pkg::bk_state_t state, state_next;

  logic [1:0]                   status [stt_pkg::MAX_ENTRIES];
  logic [stt_pkg::TICK_W-1:0]   rem_mem [stt_pkg::MAX_ENTRIES];
  logic [BQ_W-1:0]              bq_mem [stt_pkg::MAX_ENTRIES];

  logic [stt_pkg::CNT_W-1:0]    scan, scan_next;
  logic                         s1_vld, s1_vld_next;
  logic [stt_pkg::IDX_W-1:0]    s1_idx, s1_idx_next;
  logic [stt_pkg::TICK_W-1:0]   rem_q;
  logic [BQ_W-1:0]              bq_q;
  logic [stt_pkg::TICK_W-1:0]   tick_counter;
  logic                         cnt_inc;

  logic                         rd_en;
  logic                         wr_rem;
  logic                         wr_bq;
  logic [stt_pkg::IDX_W-1:0]    wr_addr;
  logic [stt_pkg::TICK_W-1:0]   rem_wdata;

  logic                         st_wr;
  logic [stt_pkg::IDX_W-1:0]    st_idx;
  logic [1:0]                   st_val;
  logic [stt_pkg::IDX_W-1:0]    st_raddr;
  logic [1:0]                   st_rdata;

  logic                         slot_free;
  logic                         emit;
  stt_pkg::kind_t               e_kind;
  logic [stt_pkg::IDX_W-1:0]    e_idx;
  logic                         e_ok;
  logic [BQ_W-1:0]              e_bq;
  logic                         e_last;

  logic                         running;
  logic                         expiring;
  logic [stt_pkg::TICK_W-1:0]   dec;

  assign slot_free = !res_valid || res_ready;
  assign st_raddr  = (state == stt_pkg::BK_TICK) ? s1_idx : scan[stt_pkg::IDX_W-1:0];
  assign st_rdata  = status[st_raddr];
  assign running   = s1_vld && (st_rdata == stt_pkg::ST_RUNNING);
  assign dec       = rem_q - stt_pkg::TICK_W'(1);
  assign expiring  = running && (rem_q == stt_pkg::TICK_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    scan_next   = scan;
    s1_vld_next = s1_vld;
    s1_idx_next = s1_idx;
    cnt_inc     = 1'b0;
    rd_en       = 1'b0;
    wr_rem      = 1'b0;
    wr_bq       = 1'b0;
    wr_addr     = q_item.idx;
    rem_wdata   = q_item.timeout;
    st_wr       = 1'b0;
    st_idx      = q_item.idx;
    st_val      = stt_pkg::ST_FREE;
    emit        = 1'b0;
    e_kind      = stt_pkg::KIND_ACK;
    e_idx       = q_item.idx;
    e_ok        = 1'b1;
    e_bq        = '0;
    e_last      = 1'b1;

    case (state)
      stt_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            stt_pkg::OP_ALLOC: begin
              q_pop      = 1'b1;
              scan_next  = '0;
              state_next = stt_pkg::BK_ALLOC;
            end
            stt_pkg::OP_BIND: begin
              if (slot_free) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                wr_bq = q_item.in_range;
              end
            end
            stt_pkg::OP_FREE: begin
              if (slot_free) begin
                q_pop  = 1'b1;
                emit   = 1'b1;
                st_wr  = q_item.in_range;
                st_val = stt_pkg::ST_FREE;
              end
            end
            stt_pkg::OP_START: begin
              if (slot_free) begin
                q_pop  = 1'b1;
                emit   = 1'b1;
                wr_rem = q_item.in_range;
                st_wr  = q_item.in_range;
                st_val = stt_pkg::ST_RUNNING;
              end
            end
            stt_pkg::OP_TICK: begin
              q_pop       = 1'b1;
              cnt_inc     = 1'b1;
              scan_next   = '0;
              s1_vld_next = 1'b0;
              state_next  = stt_pkg::BK_TICK;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      stt_pkg::BK_ALLOC: begin
        e_kind = stt_pkg::KIND_ALLOC;
        if (scan == SCAN_END) begin
          e_idx = '0;
          e_ok  = 1'b0;
          if (slot_free) begin
            emit       = 1'b1;
            state_next = stt_pkg::BK_IDLE;
          end
        end else if (st_rdata == stt_pkg::ST_FREE) begin
          e_idx  = scan[stt_pkg::IDX_W-1:0];
          st_idx = scan[stt_pkg::IDX_W-1:0];
          st_val = stt_pkg::ST_ALLOC;
          if (slot_free) begin
            emit       = 1'b1;
            st_wr      = 1'b1;
            state_next = stt_pkg::BK_IDLE;
          end
        end else begin
          scan_next = scan + stt_pkg::CNT_W'(1);
        end
      end

      stt_pkg::BK_TICK: begin
        wr_addr   = s1_idx;
        rem_wdata = dec;
        st_idx    = s1_idx;
        st_val    = stt_pkg::ST_ALLOC;
        e_idx     = s1_idx;
        e_bq      = bq_q;
        e_kind    = stt_pkg::KIND_EXPIRY;
        e_last    = 1'b0;
        // Hold the whole walk while an expiry waits for the output slot
        if (!(expiring && !slot_free)) begin
          wr_rem = running;
          if (expiring) begin
            st_wr = 1'b1;
            emit  = 1'b1;
          end
          if (scan != SCAN_END) begin
            rd_en       = 1'b1;
            s1_vld_next = 1'b1;
            s1_idx_next = scan[stt_pkg::IDX_W-1:0];
            scan_next   = scan + stt_pkg::CNT_W'(1);
          end else begin
            s1_vld_next = 1'b0;
          end
          if (scan == SCAN_END && !s1_vld) begin
            e_kind = stt_pkg::KIND_TICK_DONE;
            e_idx  = '0;
            e_bq   = '0;
            e_last = 1'b1;
            if (slot_free) begin
              emit       = 1'b1;
              state_next = stt_pkg::BK_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = stt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan         <= '0;
      s1_vld       <= 1'b0;
      s1_idx       <= '0;
      tick_counter <= '0;
    end else begin
      scan   <= scan_next;
      s1_vld <= s1_vld_next;
      s1_idx <= s1_idx_next;
      if (cnt_inc) begin
        tick_counter <= tick_counter + stt_pkg::TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stt_pkg::MAX_ENTRIES; i++) begin
        status[i] <= stt_pkg::ST_FREE;
      end
    end else if (st_wr) begin
      status[st_idx] <= st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_rem) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (rd_en) begin
      rem_q <= rem_mem[scan[stt_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_bq) begin
      bq_mem[wr_addr] <= {q_item.ev_byte, q_item.queue};
    end
    if (rd_en) begin
      bq_q <= bq_mem[scan[stt_pkg::IDX_W-1:0]];
    end
  end

  // Output register: take a new result whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= e_kind;
      entry_index <= e_idx;
      success     <= e_ok;
      fired_byte  <= e_bq[BQ_W-1:stt_pkg::QUEUE_W];
      fired_queue <= e_bq[stt_pkg::QUEUE_W-1:0];
      tick_total  <= tick_counter;
      last        <= e_last;
    end
  end

endmodule
